FILE: hdl/vec3_vector_alu_defines.svh
// ----------------------------------------------------------------------------
// vec3_vector_alu_defines
// Assertion macros shared by the vector unit checkers.
// ----------------------------------------------------------------------------
`ifndef VEC3_VECTOR_ALU_DEFINES_SVH
`define VEC3_VECTOR_ALU_DEFINES_SVH

// property holds at every edge outside reset
`define V3ALU_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition never occurs outside reset
`define V3ALU_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Operation codes, word constants and shared types of the vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

    localparam int W        = 32;
    localparam int SUM_W    = 66;
    localparam int SQ_STEPS = 32;

    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_SUB   = 3'd1;
    localparam logic [2:0] FN_SCALE = 3'd2;
    localparam logic [2:0] FN_DOT   = 3'd3;
    localparam logic [2:0] FN_CROSS = 3'd4;
    localparam logic [2:0] FN_LEN   = 3'd5;
    localparam logic [2:0] FN_NORM  = 3'd6;

    localparam logic signed [W-1:0] W_MAX = 32'sh7fff_ffff;
    localparam logic signed [W-1:0] W_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [W-1:0] val;
        logic                clip;
    } t_sat;

    typedef struct packed {
        logic [2:0]          func;
        logic signed [W-1:0] rx;
        logic signed [W-1:0] ry;
        logic signed [W-1:0] rz;
        logic                sat;
        logic                nz;
        logic [2:0][W-1:0]   mag;
        logic [2:0]          neg;
    } t_side;

    function automatic t_sat sat_word(input logic signed [SUM_W-1:0] v);
        t_sat s;
        s.clip = !((&v[SUM_W-1:W-1]) || !(|v[SUM_W-1:W-1]));
        if (s.clip) begin
            s.val = v[SUM_W-1] ? W_MIN : W_MAX;
        end else begin
            s.val = v[W-1:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/v3alu_sqrt.sv
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// rounded to nearest in a final stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic [63:0]   i_n,
    output logic      [W-1:0]  o_len
);

    logic [63:0] r_rem  [SQ_STEPS];
    logic [63:0] r_root [SQ_STEPS];
    logic [W-1:0] r_len;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] rem_in, root_in, trial, n_rem, n_root;

        always_comb begin
            rem_in  = (k == 0) ? i_n : r_rem[(k == 0) ? 0 : k - 1];
            root_in = (k == 0) ? 64'd0 : r_root[(k == 0) ? 0 : k - 1];
            trial   = root_in + BIT;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = (root_in >> 1) + BIT;
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= r_root[SQ_STEPS-1][W-1:0]
               + W'(r_rem[SQ_STEPS-1] > r_root[SQ_STEPS-1]);
    end

    assign o_len = r_len;

endmodule

`default_nettype wire

FILE: hdl/v3alu_div.sv
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined restoring divider for normalize: rounded |a| * 2^F / len,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_div
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic [W-1:0]         i_len,
    input  wire logic [W-1:0]         i_mag,
    output logic      [FRAC_BITS:0]   o_q
);

    localparam int NW = W + 1 + FRAC_BITS;

    logic [NW-1:0]      r_num [FRAC_BITS+1];
    logic [W-1:0]       r_den [FRAC_BITS+1];
    logic [FRAC_BITS:0] r_q   [FRAC_BITS+1];

    for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_step
        logic [NW-1:0]      num_in, dsh, n_num;
        logic [W-1:0]       den_in;
        logic [FRAC_BITS:0] q_in, n_q;

        always_comb begin
            if (j == 0) begin
                num_in = (NW'(i_mag) << FRAC_BITS) + NW'(i_len >> 1);
                den_in = i_len;
                q_in   = '0;
            end else begin
                num_in = r_num[(j == 0) ? 0 : j - 1];
                den_in = r_den[(j == 0) ? 0 : j - 1];
                q_in   = r_q[(j == 0) ? 0 : j - 1];
            end
            dsh = NW'(den_in) << (FRAC_BITS - j);
            if (num_in >= dsh) begin
                n_num = num_in - dsh;
                n_q   = {q_in[FRAC_BITS-1:0], 1'b1};
            end else begin
                n_num = num_in;
                n_q   = {q_in[FRAC_BITS-1:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[j] <= n_num;
            r_den[j] <= den_in;
            r_q[j]   <= n_q;
        end
    end

    assign o_q = r_q[FRAC_BITS];

endmodule

`default_nettype wire

FILE: hdl/vec3_vector_alu.sv
// ----------------------------------------------------------------------------
// vec3_vector_alu
// Three-component Q16.16 vector unit: add, sub, scale, dot, cross, length and
// normalize, with saturation and a zero-vector flag.
// ----------------------------------------------------------------------------
// Every item passes through the square root and the FRAC_BITS+1-stage divider
//   and is registered at the output before the result strobe.
// Throughput: one item per cycle; busy stays low.
// Reset: synchronous active low; clears all valid bits, drops items in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module vec3_vector_alu
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          i_func,
    input  wire logic signed [W-1:0] i_ax,
    input  wire logic signed [W-1:0] i_ay,
    input  wire logic signed [W-1:0] i_az,
    input  wire logic signed [W-1:0] i_bx,
    input  wire logic signed [W-1:0] i_by,
    input  wire logic signed [W-1:0] i_bz,
    input  wire logic signed [W-1:0] i_scalar,
    output logic                     o_valid,
    output logic signed [W-1:0]      o_rx,
    output logic signed [W-1:0]      o_ry,
    output logic signed [W-1:0]      o_rz,
    output logic                     o_saturated,
    output logic                     o_zero_vector
);

    localparam int SD      = SQ_STEPS + 2 + FRAC_BITS;
    localparam int LEN_TAP = SQ_STEPS;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    assign busy = 1'b0;

    // stage A: input register
    logic                r_a_vld;
    logic [2:0]          r_a_func;
    logic signed [W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_func <= i_func;
        r_ax     <= i_ax;
        r_ay     <= i_ay;
        r_az     <= i_az;
        r_bx     <= i_bx;
        r_by     <= i_by;
        r_bz     <= i_bz;
        r_s      <= i_scalar;
    end

    // stage B: products, add/sub, magnitudes
    logic signed [W-1:0]  op_a0, op_a1, op_a2, op_b0, op_b1, op_b2;
    logic signed [63:0]   n_m0, n_m1, n_m2, n_m3, n_m4, n_m5;
    logic signed [W:0]    n_as0, n_as1, n_as2;
    logic [2:0][W-1:0]    n_mag;
    logic [2:0]           n_neg;

    always_comb begin
        op_a0 = r_ax;
        op_a1 = r_ay;
        op_a2 = r_az;
        op_b0 = r_ax;
        op_b1 = r_ay;
        op_b2 = r_az;
        case (r_a_func)
            FN_SCALE: begin
                op_b0 = r_s;
                op_b1 = r_s;
                op_b2 = r_s;
            end
            FN_DOT: begin
                op_b0 = r_bx;
                op_b1 = r_by;
                op_b2 = r_bz;
            end
            FN_CROSS: begin
                op_a0 = r_ay;
                op_a1 = r_az;
                op_a2 = r_ax;
                op_b0 = r_bz;
                op_b1 = r_bx;
                op_b2 = r_by;
            end
            default: begin
            end
        endcase
        n_m0 = 64'(op_a0) * 64'(op_b0);
        n_m1 = 64'(op_a1) * 64'(op_b1);
        n_m2 = 64'(op_a2) * 64'(op_b2);
        n_m3 = 64'(r_az) * 64'(r_by);
        n_m4 = 64'(r_ax) * 64'(r_bz);
        n_m5 = 64'(r_ay) * 64'(r_bx);
        if (r_a_func == FN_SUB) begin
            n_as0 = (W+1)'(r_ax) - (W+1)'(r_bx);
            n_as1 = (W+1)'(r_ay) - (W+1)'(r_by);
            n_as2 = (W+1)'(r_az) - (W+1)'(r_bz);
        end else begin
            n_as0 = (W+1)'(r_ax) + (W+1)'(r_bx);
            n_as1 = (W+1)'(r_ay) + (W+1)'(r_by);
            n_as2 = (W+1)'(r_az) + (W+1)'(r_bz);
        end
        n_neg    = {r_az[W-1], r_ay[W-1], r_ax[W-1]};
        n_mag[0] = r_ax[W-1] ? W'(-r_ax) : W'(r_ax);
        n_mag[1] = r_ay[W-1] ? W'(-r_ay) : W'(r_ay);
        n_mag[2] = r_az[W-1] ? W'(-r_az) : W'(r_az);
    end

    logic                r_b_vld;
    logic [2:0]          r_b_func;
    logic signed [63:0]  r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [W:0]   r_b_as0, r_b_as1, r_b_as2;
    logic [2:0][W-1:0]   r_b_mag;
    logic [2:0]          r_b_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_func <= r_a_func;
        r_m0     <= n_m0;
        r_m1     <= n_m1;
        r_m2     <= n_m2;
        r_m3     <= n_m3;
        r_m4     <= n_m4;
        r_m5     <= n_m5;
        r_b_as0  <= n_as0;
        r_b_as1  <= n_as1;
        r_b_as2  <= n_as2;
        r_b_mag  <= n_mag;
        r_b_neg  <= n_neg;
    end

    // stage C: product sums with rounding offset
    logic signed [SUM_W-1:0] sum3, n_t0, n_t1, n_t2;

    always_comb begin
        sum3 = SUM_W'(r_m0) + SUM_W'(r_m1) + SUM_W'(r_m2);
        n_t0 = '0;
        n_t1 = '0;
        n_t2 = '0;
        case (r_b_func)
            FN_SCALE: begin
                n_t0 = SUM_W'(r_m0) + HALF;
                n_t1 = SUM_W'(r_m1) + HALF;
                n_t2 = SUM_W'(r_m2) + HALF;
            end
            FN_DOT: begin
                n_t0 = sum3 + HALF;
            end
            FN_CROSS: begin
                n_t0 = SUM_W'(r_m0) - SUM_W'(r_m3) + HALF;
                n_t1 = SUM_W'(r_m1) - SUM_W'(r_m4) + HALF;
                n_t2 = SUM_W'(r_m2) - SUM_W'(r_m5) + HALF;
            end
            default: begin
            end
        endcase
    end

    logic                    r_c_vld;
    logic [2:0]              r_c_func;
    logic signed [SUM_W-1:0] r_t0, r_t1, r_t2;
    logic [63:0]             r_c_n;
    logic signed [W:0]       r_c_as0, r_c_as1, r_c_as2;
    logic [2:0][W-1:0]       r_c_mag;
    logic [2:0]              r_c_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_func <= r_b_func;
        r_t0     <= n_t0;
        r_t1     <= n_t1;
        r_t2     <= n_t2;
        r_c_n    <= sum3[63:0];
        r_c_as0  <= r_b_as0;
        r_c_as1  <= r_b_as1;
        r_c_as2  <= r_b_as2;
        r_c_mag  <= r_b_mag;
        r_c_neg  <= r_b_neg;
    end

    // stage D: shift, saturate, select
    t_sat  s_as0, s_as1, s_as2, s_t0, s_t1, s_t2;
    t_side n_early;

    always_comb begin
        s_as0 = sat_word(SUM_W'(r_c_as0));
        s_as1 = sat_word(SUM_W'(r_c_as1));
        s_as2 = sat_word(SUM_W'(r_c_as2));
        s_t0  = sat_word(r_t0 >>> FRAC_BITS);
        s_t1  = sat_word(r_t1 >>> FRAC_BITS);
        s_t2  = sat_word(r_t2 >>> FRAC_BITS);
        n_early.func = r_c_func;
        n_early.rx   = '0;
        n_early.ry   = '0;
        n_early.rz   = '0;
        n_early.sat  = 1'b0;
        n_early.nz   = (r_c_n == 64'd0);
        n_early.mag  = r_c_mag;
        n_early.neg  = r_c_neg;
        case (r_c_func)
            FN_ADD, FN_SUB: begin
                n_early.rx  = s_as0.val;
                n_early.ry  = s_as1.val;
                n_early.rz  = s_as2.val;
                n_early.sat = s_as0.clip || s_as1.clip || s_as2.clip;
            end
            FN_SCALE, FN_CROSS: begin
                n_early.rx  = s_t0.val;
                n_early.ry  = s_t1.val;
                n_early.rz  = s_t2.val;
                n_early.sat = s_t0.clip || s_t1.clip || s_t2.clip;
            end
            FN_DOT: begin
                n_early.rx  = s_t0.val;
                n_early.sat = s_t0.clip;
            end
            default: begin
            end
        endcase
    end

    // length and normalize units
    logic [W-1:0]       len;
    logic [FRAC_BITS:0] q [3];

    v3alu_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_n   (r_c_n),
        .o_len (len)
    );

    t_side r_sd     [SD];
    logic  r_sd_vld [SD];

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3alu_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_len (len),
            .i_mag (r_sd[LEN_TAP].mag[i]),
            .o_q   (q[i])
        );
    end

    // side line: hold results and operands alongside the long units
    t_side n_len_upd;

    always_comb begin
        n_len_upd = r_sd[LEN_TAP];
        if (r_sd[LEN_TAP].func == FN_LEN) begin
            n_len_upd.rx  = len[W-1] ? W_MAX : $signed(len);
            n_len_upd.sat = len[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SD; k++) begin
            if (!i_rst_n) begin
                r_sd_vld[k] <= 1'b0;
            end else if (k == 0) begin
                r_sd_vld[k] <= r_c_vld;
            end else begin
                r_sd_vld[k] <= r_sd_vld[(k == 0) ? 0 : k - 1];
            end
        end
        r_sd[0] <= n_early;
        for (int k = 1; k < SD; k++) begin
            if (k == LEN_TAP + 1) begin
                r_sd[k] <= n_len_upd;
            end else begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // output register
    t_side               last;
    logic signed [W-1:0] n_rx, n_ry, n_rz, qx, qy, qz;
    logic                n_sat, n_zero;

    always_comb begin
        last   = r_sd[SD-1];
        qx     = $signed(W'(q[0]));
        qy     = $signed(W'(q[1]));
        qz     = $signed(W'(q[2]));
        n_rx   = last.rx;
        n_ry   = last.ry;
        n_rz   = last.rz;
        n_sat  = last.sat;
        n_zero = 1'b0;
        if (last.func == FN_NORM) begin
            n_sat = 1'b0;
            if (last.nz) begin
                n_rx   = '0;
                n_ry   = '0;
                n_rz   = '0;
                n_zero = 1'b1;
            end else begin
                n_rx = last.neg[0] ? -qx : qx;
                n_ry = last.neg[1] ? -qy : qy;
                n_rz = last.neg[2] ? -qz : qz;
            end
        end
    end

    logic r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_sd_vld[SD-1];
        end
        o_rx          <= n_rx;
        o_ry          <= n_ry;
        o_rz          <= n_rz;
        o_saturated   <= n_sat;
        o_zero_vector <= n_zero;
    end

    assign o_valid = r_o_vld;

endmodule

`default_nettype wire

FILE: hdl/v3alu_chk.sv
// ----------------------------------------------------------------------------
// v3alu_chk
// Port-level checks of the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "vec3_vector_alu_defines.svh"
`default_nettype none

module v3alu_chk #(
    parameter int FRAC_BITS = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [31:0] o_rx,
    input wire logic [31:0] o_ry,
    input wire logic [31:0] o_rz,
    input wire logic        o_saturated,
    input wire logic        o_zero_vector
);

    localparam int LAT = 38 + FRAC_BITS;

    `V3ALU_CHECK(a_never_busy, i_clk, i_rst_n, busy == 1'b0, "busy raised")
    `V3ALU_CHECK(a_latency, i_clk, i_rst_n, o_valid |-> $past(start, LAT), "item without start")
    `V3ALU_NEVER(a_zero_clean, i_clk, i_rst_n, o_zero_vector && (o_rx != 0 || o_ry != 0 || o_rz != 0 || o_saturated), "zero vector not clean")

endmodule

bind vec3_vector_alu v3alu_chk #(
    .FRAC_BITS (FRAC_BITS)
) u_v3alu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_rx          (o_rx),
    .o_ry          (o_ry),
    .o_rz          (o_rz),
    .o_saturated   (o_saturated),
    .o_zero_vector (o_zero_vector)
);

`default_nettype wire

FILE: tb/tb_vec3_vector_alu.sv
// ----------------------------------------------------------------------------
// tb_vec3_vector_alu
// Drives operation items into the vector unit with random gaps or back to back,
// predicts each result in fixed point and checks every strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import v3alu_pkg::*;

typedef struct {
    logic [2:0]          func;
    logic signed [31:0]  a [3];
    logic signed [31:0]  b [3];
    logic signed [31:0]  scalar;
} t_vec_op;

typedef struct {
    logic signed [31:0]  r [3];
    logic                sat;
    logic                zv;
} t_vec_res;

class t_vec_alu_scoreboard;
    localparam int FRAC = 16;
    t_vec_res pending_results[$];
    int       mismatches;

    function new();
        mismatches = 0;
    endfunction

    function logic signed [31:0] clip(input logic signed [127:0] v, inout logic flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return W_MAX;
        end
        if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return W_MIN;
        end
        return v[31:0];
    endfunction

    function logic signed [127:0] round_q(input logic signed [127:0] v);
        return (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function logic [63:0] sqrt_near(input logic [63:0] n);
        logic [63:0] rem, r, bit_w, f;
        rem = n;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= r + bit_w) begin
                rem = rem - (r + bit_w);
                r = (r >> 1) + bit_w;
            end else begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        f = n - r * r;
        return (f > r) ? r + 1 : r;
    endfunction

    function t_vec_res vec_op_predict(input t_vec_op op);
        t_vec_res res;
        logic signed [127:0] a [3], b [3], s;
        logic [63:0] n, len, m, q;
        int j, k;
        res.sat = 1'b0;
        res.zv = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res.r[i] = 0;
            a[i] = op.a[i];
            b[i] = op.b[i];
        end
        s = op.scalar;
        case (op.func)
            FN_ADD: for (int i = 0; i < 3; i++) res.r[i] = clip(a[i] + b[i], res.sat);
            FN_SUB: for (int i = 0; i < 3; i++) res.r[i] = clip(a[i] - b[i], res.sat);
            FN_SCALE: for (int i = 0; i < 3; i++) res.r[i] = clip(round_q(a[i] * s), res.sat);
            FN_DOT: res.r[0] = clip(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]),
                                    res.sat);
            FN_CROSS: for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                res.r[i] = clip(round_q(a[j] * b[k] - a[k] * b[j]), res.sat);
            end
            FN_LEN, FN_NORM: begin
                n = 0;
                for (int i = 0; i < 3; i++) n = n + 64'(a[i] * a[i]);
                len = sqrt_near(n);
                if (op.func == FN_LEN) begin
                    res.r[0] = clip($signed({64'd0, len}), res.sat);
                end else if (n == 0) begin
                    res.zv = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        m = 64'(a[i] < 0 ? -a[i] : a[i]);
                        q = ((m << FRAC) + (len >> 1)) / len;
                        res.r[i] = clip(a[i] < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q}),
                                        res.sat);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function void note_item(input t_vec_op op);
        pending_results.push_back(vec_op_predict(op));
    endfunction

    function void check_result(input t_vec_res got);
        t_vec_res exp_r;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result rx=%h", got.r[0]);
            return;
        end
        exp_r = pending_results.pop_front();
        if (got.r[0] !== exp_r.r[0] || got.r[1] !== exp_r.r[1] || got.r[2] !== exp_r.r[2]
            || got.sat !== exp_r.sat || got.zv !== exp_r.zv) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp %h %h %h s%b z%b got %h %h %h s%b z%b",
                         exp_r.r[0], exp_r.r[1], exp_r.r[2], exp_r.sat, exp_r.zv,
                         got.r[0], got.r[1], got.r[2], got.sat, got.zv);
        end
    endfunction
endclass

module tb_vec3_vector_alu;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [2:0] FN_UNDEF = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        i_func = '0;
    logic signed [31:0] i_ax = '0, i_ay = '0, i_az = '0;
    logic signed [31:0] i_bx = '0, i_by = '0, i_bz = '0, i_scalar = '0;
    logic              o_valid;
    logic signed [31:0] o_rx, o_ry, o_rz;
    logic              o_saturated, o_zero_vector;

    t_vec_alu_scoreboard board = new();
    int  idle_cycles = 0;
    bit  no_gaps = 0;

    vec3_vector_alu u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by(i_by), .i_bz(i_bz), .i_scalar(i_scalar),
        .o_valid(o_valid), .o_rx(o_rx), .o_ry(o_ry), .o_rz(o_rz),
        .o_saturated(o_saturated), .o_zero_vector(o_zero_vector)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_vec_res got;
        if (i_rst_n && o_valid) begin
            got.r[0] = o_rx;
            got.r[1] = o_ry;
            got.r[2] = o_rz;
            got.sat = o_saturated;
            got.zv = o_zero_vector;
            board.check_result(got);
        end
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("vec3_vector_alu test failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return W_MAX - $urandom_range(0, 2);
            1: return W_MIN + $urandom_range(0, 2);
            2: return $signed($urandom_range(0, 2 * (3 << 16))) - (3 << 16);
            3: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            4: return $signed($urandom_range(0, 4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_vec_op op);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= op.func;
        i_ax <= op.a[0];
        i_ay <= op.a[1];
        i_az <= op.a[2];
        i_bx <= op.b[0];
        i_by <= op.b[1];
        i_bz <= op.b[2];
        i_scalar <= op.scalar;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(op);
    endtask

    task automatic send_fields(input logic [2:0] f, input logic signed [31:0] x,
                               input logic signed [31:0] y, input logic signed [31:0] z,
                               input logic signed [31:0] u, input logic signed [31:0] v,
                               input logic signed [31:0] w, input logic signed [31:0] s);
        t_vec_op op;
        op.func = f;
        op.a[0] = x; op.a[1] = y; op.a[2] = z;
        op.b[0] = u; op.b[1] = v; op.b[2] = w;
        op.scalar = s;
        send_item(op);
    endtask

    initial begin
        t_vec_op op;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fields(FN_ADD, W_MAX, W_MIN, 1, 1, -1, 5, 0);
        send_fields(FN_SUB, W_MIN, W_MAX, 7, 1, -1, 7, 0);
        send_fields(FN_SCALE, W_MAX, W_MIN, -65536, 0, 0, 0, W_MIN);
        send_fields(FN_SCALE, 3, -3, 1, 0, 0, 0, 32768);
        send_fields(FN_DOT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 0);
        send_fields(FN_DOT, 65536, 131072, -65536, 65536, 65536, 65536, 0);
        send_fields(FN_CROSS, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, 0);
        send_fields(FN_CROSS, 65536, 0, 0, 0, 65536, 0, 0);
        send_fields(FN_LEN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0);
        send_fields(FN_LEN, 3 << 16, 4 << 16, 0, 0, 0, 0, 0);
        send_fields(FN_LEN, 0, 0, 0, 0, 0, 0, 0);
        send_fields(FN_NORM, 0, 0, 0, 1, 2, 3, 4);
        send_fields(FN_NORM, 1, 0, 0, 0, 0, 0, 0);
        send_fields(FN_NORM, W_MIN, 0, 0, 0, 0, 0, 0);
        send_fields(FN_NORM, -3, 4, -5, 0, 0, 0, 0);
        send_fields(FN_NORM, W_MAX, W_MIN, 1, 0, 0, 0, 0);
        send_fields(FN_UNDEF, -1, -1, -1, -1, -1, -1, -1);
        send_fields(FN_ADD, 0, 0, 0, 0, 0, 0, 0);

        for (int n = 0; n < 950; n++) begin
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            op.func = ($urandom_range(0, 30) == 0) ? FN_UNDEF : 3'($urandom_range(0, 6));
            for (int i = 0; i < 3; i++) begin
                op.a[i] = rand_word();
                op.b[i] = rand_word();
            end
            if (op.func == FN_NORM && $urandom_range(0, 9) == 0) begin
                op.a[0] = 0; op.a[1] = 0; op.a[2] = 0;
            end
            op.scalar = rand_word();
            send_item(op);
        end
        start <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("vec3_vector_alu test passed");
        end else begin
            $display("vec3_vector_alu test failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/v3alu_pkg.sv
hdl/v3alu_sqrt.sv
hdl/v3alu_div.sv
hdl/vec3_vector_alu.sv
hdl/v3alu_chk.sv
tb/tb_vec3_vector_alu.sv
